// File: rtl/core/bfa_pkg.sv
// Shared types and constants for the bidirectional flow accounting block.
package bfa_pkg;

  localparam int unsigned AddrW   = 32;
  localparam int unsigned PortW   = 16;
  localparam int unsigned ProtoW  = 8;
  localparam int unsigned LenW    = 16;
  localparam int unsigned BytesW  = 48;
  localparam int unsigned PktsW   = 32;
  localparam int unsigned SlotW   = 5;
  // words held between the front and the back
  localparam int unsigned QueueDepth = 2;

  // canonical flow key: lower endpoint first
  typedef struct packed {
    logic [AddrW-1:0] lo_addr;
    logic [PortW-1:0] lo_port;
    logic [AddrW-1:0] hi_addr;
    logic [PortW-1:0] hi_port;
  } key_t;

  typedef struct packed {
    key_t              key;
    logic [ProtoW-1:0] proto;
    logic [LenW-1:0]   len;
  } item_t;

  // per-flow counters kept in RAM
  typedef struct packed {
    logic [ProtoW-1:0] proto;
    logic [BytesW-1:0] bytes;
    logic [PktsW-1:0]  pkts;
  } totals_t;

  typedef enum logic {
    BK_LOOKUP,
    BK_UPDATE
  } back_state_e;

endpackage

// File: rtl/core/bfa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bfa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/bfa_front.sv
// Front end: takes packet headers and puts the two endpoints in canonical order.
module bfa_front (
  input  logic                        push,
  output logic                        full,
  input  logic [bfa_pkg::AddrW-1:0]   source_address_i,
  input  logic [bfa_pkg::PortW-1:0]   source_port_i,
  input  logic [bfa_pkg::AddrW-1:0]   dest_address_i,
  input  logic [bfa_pkg::PortW-1:0]   dest_port_i,
  input  logic [bfa_pkg::ProtoW-1:0]  proto_number_i,
  input  logic [bfa_pkg::LenW-1:0]    packet_length_i,
  output logic                        q_push_o,
  input  logic                        q_full_i,
  output bfa_pkg::item_t              q_item_o
);

  logic src_first;

  // tuple compare, address first then port
  assign src_first = (source_address_i < dest_address_i) ||
                     ((source_address_i == dest_address_i) && (source_port_i < dest_port_i));

  always_comb begin
    q_item_o.proto = proto_number_i;
    q_item_o.len   = packet_length_i;
    if (src_first) begin
      q_item_o.key.lo_addr = source_address_i;
      q_item_o.key.lo_port = source_port_i;
      q_item_o.key.hi_addr = dest_address_i;
      q_item_o.key.hi_port = dest_port_i;
    end else begin
      q_item_o.key.lo_addr = dest_address_i;
      q_item_o.key.lo_port = dest_port_i;
      q_item_o.key.hi_addr = source_address_i;
      q_item_o.key.hi_port = source_port_i;
    end
  end

  assign full     = q_full_i;
  assign q_push_o = push && !q_full_i;

endmodule

// File: rtl/core/bfa_queue.sv
// Short word queue between the front end and the table back end.
module bfa_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  bfa_pkg::item_t wdata_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output bfa_pkg::item_t rdata_o
);

  localparam int unsigned Depth = bfa_pkg::QueueDepth;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  bfa_pkg::item_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// File: rtl/core/bfa_back.sv
// Back end: associative key lookup, counter RAM update and result register.
module bfa_back #(
  parameter int unsigned FLOW_ENTRIES = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  input  bfa_pkg::item_t              q_item_i,
  output logic                        q_pop_o,
  output logic                        empty,
  input  logic                        pop,
  output logic [bfa_pkg::SlotW-1:0]   flow_slot_o,
  output logic                        new_flow_o,
  output logic                        table_full_o,
  output logic [bfa_pkg::BytesW-1:0]  flow_bytes_o,
  output logic [bfa_pkg::PktsW-1:0]   flow_packets_o
);

  localparam int unsigned IdxW = $clog2(FLOW_ENTRIES);

  bfa_pkg::back_state_e state_q, state_d;

  logic [FLOW_ENTRIES-1:0] valid_q, valid_d;
  bfa_pkg::key_t           key_q [FLOW_ENTRIES];
  logic [FLOW_ENTRIES-1:0] match;

  logic            hit_found, free_found;
  logic [IdxW-1:0] hit_idx, free_idx;

  logic [IdxW-1:0] slot_q, slot_d;
  logic            hit_q, hit_d, create_q, create_d;

  logic             ram_re, ram_we;
  bfa_pkg::totals_t ram_rdata, ram_wdata;

  logic                      out_valid_q, out_valid_d;
  logic [bfa_pkg::SlotW-1:0] out_slot_q, out_slot_d;
  logic                      out_new_q, out_new_d, out_full_q, out_full_d;
  logic [bfa_pkg::BytesW-1:0] out_bytes_q, out_bytes_d;
  logic [bfa_pkg::PktsW-1:0]  out_pkts_q, out_pkts_d;

  logic [bfa_pkg::BytesW:0]   bytes_sum;
  logic [bfa_pkg::BytesW-1:0] bytes_upd;
  logic [bfa_pkg::PktsW-1:0]  pkts_upd;
  logic                       can_load;

  // tag compare against every entry
  always_comb begin
    for (int i = 0; i < FLOW_ENTRIES; i++) begin
      match[i] = valid_q[i] && (key_q[i] == q_item_i.key);
    end
  end

  // lowest-numbered hit and lowest-numbered free entry
  always_comb begin
    hit_found  = 1'b0;
    hit_idx    = '0;
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = FLOW_ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_found = 1'b1;
        hit_idx   = IdxW'(i);
      end
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = IdxW'(i);
      end
    end
  end

  assign bytes_sum = {1'b0, ram_rdata.bytes} + (bfa_pkg::BytesW + 1)'(q_item_i.len);
  assign bytes_upd = bytes_sum[bfa_pkg::BytesW] ? '1 : bytes_sum[bfa_pkg::BytesW-1:0];
  assign pkts_upd  = (ram_rdata.pkts == '1) ? ram_rdata.pkts : ram_rdata.pkts + 1'b1;
  assign can_load  = !out_valid_q || pop;

  always_comb begin
    state_d     = state_q;
    slot_d      = slot_q;
    hit_d       = hit_q;
    create_d    = create_q;
    valid_d     = valid_q;
    ram_re      = 1'b0;
    ram_we      = 1'b0;
    ram_wdata   = '0;
    q_pop_o     = 1'b0;
    out_valid_d = out_valid_q && !pop;
    out_slot_d  = out_slot_q;
    out_new_d   = out_new_q;
    out_full_d  = out_full_q;
    out_bytes_d = out_bytes_q;
    out_pkts_d  = out_pkts_q;
    case (state_q)
      bfa_pkg::BK_LOOKUP: begin
        if (q_valid_i) begin
          hit_d    = hit_found;
          create_d = !hit_found && free_found;
          slot_d   = hit_found ? hit_idx : free_idx;
          ram_re   = 1'b1;
          state_d  = bfa_pkg::BK_UPDATE;
        end
      end
      bfa_pkg::BK_UPDATE: begin
        if (can_load) begin
          q_pop_o     = 1'b1;
          out_valid_d = 1'b1;
          state_d     = bfa_pkg::BK_LOOKUP;
          if (hit_q) begin
            ram_we          = 1'b1;
            ram_wdata.proto = q_item_i.proto;
            ram_wdata.bytes = bytes_upd;
            ram_wdata.pkts  = pkts_upd;
            out_slot_d      = bfa_pkg::SlotW'(slot_q);
            out_new_d       = 1'b0;
            out_full_d      = 1'b0;
            out_bytes_d     = bytes_upd;
            out_pkts_d      = pkts_upd;
          end else if (create_q) begin
            ram_we          = 1'b1;
            ram_wdata.proto = q_item_i.proto;
            ram_wdata.bytes = bfa_pkg::BytesW'(q_item_i.len);
            ram_wdata.pkts  = bfa_pkg::PktsW'(1);
            valid_d[slot_q] = 1'b1;
            out_slot_d      = bfa_pkg::SlotW'(slot_q);
            out_new_d       = 1'b1;
            out_full_d      = 1'b0;
            out_bytes_d     = bfa_pkg::BytesW'(q_item_i.len);
            out_pkts_d      = bfa_pkg::PktsW'(1);
          end else begin
            // no free entry: nothing counted, result fields zero
            out_slot_d  = '0;
            out_new_d   = 1'b0;
            out_full_d  = 1'b1;
            out_bytes_d = '0;
            out_pkts_d  = '0;
          end
        end
      end
      default: begin
        state_d = bfa_pkg::BK_LOOKUP;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bfa_pkg::BK_LOOKUP;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q      <= slot_d;
    hit_q       <= hit_d;
    create_q    <= create_d;
    out_slot_q  <= out_slot_d;
    out_new_q   <= out_new_d;
    out_full_q  <= out_full_d;
    out_bytes_q <= out_bytes_d;
    out_pkts_q  <= out_pkts_d;
    if (state_q == bfa_pkg::BK_UPDATE && can_load && create_q) begin
      key_q[slot_q] <= q_item_i.key;
    end
  end

  bfa_ram #(
    .WIDTH ($bits(bfa_pkg::totals_t)),
    .DEPTH (FLOW_ENTRIES)
  ) u_totals_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (hit_idx),
    .rdata_o (ram_rdata)
  );

  assign empty          = !out_valid_q;
  assign flow_slot_o    = out_slot_q;
  assign new_flow_o     = out_new_q;
  assign table_full_o   = out_full_q;
  assign flow_bytes_o   = out_bytes_q;
  assign flow_packets_o = out_pkts_q;

endmodule

// File: rtl/core/bidirectional_flow_accounting.sv
// Bidirectional flow accounting: top level with front end, queue and table back end.
//
// Each packet header pushed in gives one result word: the flow's slot and its updated
// byte and packet totals, or table_full when the flow is new and no entry is free.
// The front end orders the two endpoints and writes the canonical key into a two-word
// queue, so headers are taken while the back end works. The back end handles one header
// at a time: a lookup state for the parallel key compare over all FLOW_ENTRIES entries
// and the counter RAM read, then an update state for the saturating update, RAM write and
// loading the result register. Headers do not overlap, because of the registered counter
// RAM read: the entry is read in the lookup state and written back in the update state
// before the next lookup starts. A result waits in its register until popped;
// meanwhile the back end holds the next header. No clearing pass after reset.
module bidirectional_flow_accounting #(
  parameter int unsigned FLOW_ENTRIES = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic [bfa_pkg::AddrW-1:0]   source_address_i,
  input  logic [bfa_pkg::PortW-1:0]   source_port_i,
  input  logic [bfa_pkg::AddrW-1:0]   dest_address_i,
  input  logic [bfa_pkg::PortW-1:0]   dest_port_i,
  input  logic [bfa_pkg::ProtoW-1:0]  proto_number_i,
  input  logic [bfa_pkg::LenW-1:0]    packet_length_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [bfa_pkg::SlotW-1:0]   flow_slot_o,
  output logic                        new_flow_o,
  output logic                        table_full_o,
  output logic [bfa_pkg::BytesW-1:0]  flow_bytes_o,
  output logic [bfa_pkg::PktsW-1:0]   flow_packets_o
);

  logic           q_push, q_full, q_valid, q_pop;
  bfa_pkg::item_t q_wdata, q_rdata;

  bfa_front u_front (
    .push             (push),
    .full             (full),
    .source_address_i (source_address_i),
    .source_port_i    (source_port_i),
    .dest_address_i   (dest_address_i),
    .dest_port_i      (dest_port_i),
    .proto_number_i   (proto_number_i),
    .packet_length_i  (packet_length_i),
    .q_push_o         (q_push),
    .q_full_i         (q_full),
    .q_item_o         (q_wdata)
  );

  bfa_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (q_rdata)
  );

  bfa_back #(
    .FLOW_ENTRIES (FLOW_ENTRIES)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_item_i       (q_rdata),
    .q_pop_o        (q_pop),
    .empty          (empty),
    .pop            (pop),
    .flow_slot_o    (flow_slot_o),
    .new_flow_o     (new_flow_o),
    .table_full_o   (table_full_o),
    .flow_bytes_o   (flow_bytes_o),
    .flow_packets_o (flow_packets_o)
  );

  // a full-table word carries no counts
  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && table_full_o) |-> (flow_packets_o == '0 && flow_bytes_o == '0 && !new_flow_o))
    else $error("table_full word with nonzero fields");

  // a counted packet always leaves a nonzero packet count
  a_counted_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !table_full_o) |-> (flow_packets_o != '0))
    else $error("counted word with zero packet count");

  // a newly created flow has seen exactly one packet
  a_new_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && new_flow_o) |-> (flow_packets_o == 1 && !table_full_o))
    else $error("new flow word with wrong packet count");

endmodule
